[hw/rtl/amwd_pkg.sv]
`timescale 1ns / 1ps

package amwd_pkg;

    // Default geometry
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ENERGY_BITS_DEF = 48;
    localparam int TICK_BITS_DEF   = 24;

    // Fixed field widths
    localparam int OP_BITS      = 3;
    localparam int CFG_IDX_BITS = 3;
    localparam int LIMIT_BITS   = 32;

    // Divisor of the limit in repeated mode
    localparam int LIMIT_DIV = 15;

    // Register reset values
    localparam int unsigned SENSE_TICKS_RST   = 1000;
    localparam int unsigned REST_TICKS_RST    = 1000;
    localparam int unsigned OVERALL_TICKS_RST = 10000;
    localparam int unsigned MOTION_LIMIT_RST  = 1000;

    // Request operations
    typedef enum logic [OP_BITS-1:0] {
        OP_START  = 3'd0,
        OP_SAMPLE = 3'd1,
        OP_MOTION = 3'd2,
        OP_TICK   = 3'd3,
        OP_STOP   = 3'd4
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SENSE_TICKS   = 3'd0,
        CFG_REST_TICKS    = 3'd1,
        CFG_OVERALL_TICKS = 3'd2,
        CFG_MOTION_LIMIT  = 3'd3,
        CFG_REPEATED_MODE = 3'd4
    } cfg_idx_t;

    // Detector phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SENSE = 2'd1,
        PH_REST  = 2'd2
    } phase_t;

    // Verdict strobe from the sequencer to the result register
    typedef struct packed {
        logic valid;
        logic moved;
    } verdict_t;

endpackage

[hw/rtl/amwd_energy.sv]
`timescale 1ns / 1ps

// Squared distance of one sample from the reference, saturating accumulate
// and threshold compare.
module amwd_energy #(
    parameter int SAMPLE_BITS = amwd_pkg::SAMPLE_BITS_DEF,
    parameter int ENERGY_BITS = amwd_pkg::ENERGY_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0]   x,
    input  logic signed [SAMPLE_BITS-1:0]   y,
    input  logic signed [SAMPLE_BITS-1:0]   z,
    input  logic                            have_ref,
    input  logic signed [SAMPLE_BITS-1:0]   ref_x,
    input  logic signed [SAMPLE_BITS-1:0]   ref_y,
    input  logic signed [SAMPLE_BITS-1:0]   ref_z,
    input  logic [ENERGY_BITS-1:0]          energy,
    input  logic [amwd_pkg::LIMIT_BITS-1:0] motion_limit,
    input  logic                            repeated_mode,
    output logic [ENERGY_BITS-1:0]          energy_sum,
    output logic                            over_limit
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int ADD_W  = SQ_W + 2;
    localparam int SUM_W  = ((ENERGY_BITS > ADD_W) ? ENERGY_BITS : ADD_W) + 1;
    localparam int CMP_W  = ((ENERGY_BITS > amwd_pkg::LIMIT_BITS) ?
                             ENERGY_BITS : amwd_pkg::LIMIT_BITS) + 4;

    logic signed [SAMPLE_BITS-1:0] rx, ry, rz;
    logic signed [DIFF_W-1:0]      dx, dy, dz;
    logic signed [2*DIFF_W-1:0]    px, py, pz;
    logic [SQ_W-1:0]               sqx, sqy, sqz;
    logic [ADD_W-1:0]              add;
    logic [SUM_W-1:0]              total;
    logic [CMP_W-1:0]              e_cmp;
    logic [CMP_W-1:0]              lim_cmp;

    // First sample of a window is its own reference
    assign rx = have_ref ? ref_x : x;
    assign ry = have_ref ? ref_y : y;
    assign rz = have_ref ? ref_z : z;

    // Axis differences and squares
    assign dx = DIFF_W'(x) - DIFF_W'(rx);
    assign dy = DIFF_W'(y) - DIFF_W'(ry);
    assign dz = DIFF_W'(z) - DIFF_W'(rz);

    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    assign sqx = SQ_W'(px);
    assign sqy = SQ_W'(py);
    assign sqz = SQ_W'(pz);

    assign add = ADD_W'(sqx) + ADD_W'(sqy) + ADD_W'(sqz);

    // Saturating accumulate
    assign total      = SUM_W'(energy) + SUM_W'(add);
    assign energy_sum = (|total[SUM_W-1:ENERGY_BITS]) ? '1 : total[ENERGY_BITS-1:0];

    // energy > floor(limit / 15) is the same as 15 * energy > limit
    assign e_cmp   = CMP_W'(energy_sum);
    assign lim_cmp = CMP_W'(motion_limit);

    always_comb
    begin
        if (repeated_mode)
        begin
            over_limit = (e_cmp * CMP_W'(amwd_pkg::LIMIT_DIV)) > lim_cmp;
        end
        else
        begin
            over_limit = e_cmp > lim_cmp;
        end
    end

endmodule

[hw/rtl/amwd_seq.sv]
`timescale 1ns / 1ps

// Window sequencer: phase, tick counters, reference and energy state.
module amwd_seq #(
    parameter int SAMPLE_BITS = amwd_pkg::SAMPLE_BITS_DEF,
    parameter int ENERGY_BITS = amwd_pkg::ENERGY_BITS_DEF,
    parameter int TICK_BITS   = amwd_pkg::TICK_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic [amwd_pkg::OP_BITS-1:0]    op,
    input  logic signed [SAMPLE_BITS-1:0]   x,
    input  logic signed [SAMPLE_BITS-1:0]   y,
    input  logic signed [SAMPLE_BITS-1:0]   z,
    input  logic [TICK_BITS-1:0]            sense_ticks,
    input  logic [TICK_BITS-1:0]            rest_ticks,
    input  logic [TICK_BITS-1:0]            overall_ticks,
    input  logic [amwd_pkg::LIMIT_BITS-1:0] motion_limit,
    input  logic                            repeated_mode,
    output amwd_pkg::verdict_t              verdict,
    output logic [ENERGY_BITS-1:0]          verdict_energy
);

    amwd_pkg::phase_t              phase_reg, phase_next;
    logic [TICK_BITS-1:0]          phase_count_reg, phase_count_next;
    logic [TICK_BITS-1:0]          overall_count_reg, overall_count_next;
    logic [ENERGY_BITS-1:0]        energy_reg, energy_next;
    logic                          have_ref_reg, have_ref_next;
    logic signed [SAMPLE_BITS-1:0] ref_x_reg, ref_x_next;
    logic signed [SAMPLE_BITS-1:0] ref_y_reg, ref_y_next;
    logic signed [SAMPLE_BITS-1:0] ref_z_reg, ref_z_next;

    logic [ENERGY_BITS-1:0] sum_sat;
    logic                   over_limit;
    logic [TICK_BITS-1:0]   overall_inc;
    logic [TICK_BITS-1:0]   phase_inc;
    logic                   overall_done;
    logic                   in_sense;

    amwd_energy #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENERGY_BITS (ENERGY_BITS)
    ) u_energy (
        .x             (x),
        .y             (y),
        .z             (z),
        .have_ref      (have_ref_reg),
        .ref_x         (ref_x_reg),
        .ref_y         (ref_y_reg),
        .ref_z         (ref_z_reg),
        .energy        (energy_reg),
        .motion_limit  (motion_limit),
        .repeated_mode (repeated_mode),
        .energy_sum    (sum_sat),
        .over_limit    (over_limit)
    );

    // Counter increments wrap at the tick width
    assign overall_inc  = overall_count_reg + TICK_BITS'(1);
    assign phase_inc    = phase_count_reg + TICK_BITS'(1);
    assign overall_done = overall_inc >= overall_ticks;
    assign in_sense     = phase_reg == amwd_pkg::PH_SENSE;

    // Next state
    always_comb
    begin
        phase_next         = phase_reg;
        phase_count_next   = phase_count_reg;
        overall_count_next = overall_count_reg;
        energy_next        = energy_reg;
        have_ref_next      = have_ref_reg;
        ref_x_next         = ref_x_reg;
        ref_y_next         = ref_y_reg;
        ref_z_next         = ref_z_reg;
        if (item_valid)
        begin
            case (op)
                amwd_pkg::OP_START:
                begin
                    overall_count_next = '0;
                    phase_next         = amwd_pkg::PH_SENSE;
                    phase_count_next   = '0;
                    energy_next        = '0;
                    have_ref_next      = 1'b0;
                end
                amwd_pkg::OP_STOP:
                begin
                    phase_next       = amwd_pkg::PH_IDLE;
                    phase_count_next = '0;
                    have_ref_next    = 1'b0;
                end
                amwd_pkg::OP_SAMPLE:
                begin
                    if (in_sense)
                    begin
                        if (!have_ref_reg)
                        begin
                            have_ref_next = 1'b1;
                            ref_x_next    = x;
                            ref_y_next    = y;
                            ref_z_next    = z;
                        end
                        energy_next = sum_sat;
                        if (over_limit)
                        begin
                            phase_next       = amwd_pkg::PH_IDLE;
                            phase_count_next = '0;
                            have_ref_next    = 1'b0;
                        end
                    end
                end
                amwd_pkg::OP_MOTION:
                begin
                    if (in_sense)
                    begin
                        phase_next       = amwd_pkg::PH_IDLE;
                        phase_count_next = '0;
                        have_ref_next    = 1'b0;
                    end
                end
                amwd_pkg::OP_TICK:
                begin
                    if (phase_reg != amwd_pkg::PH_IDLE)
                    begin
                        overall_count_next = overall_inc;
                        if (overall_done)
                        begin
                            phase_next       = amwd_pkg::PH_IDLE;
                            phase_count_next = '0;
                            have_ref_next    = 1'b0;
                        end
                        else if (in_sense)
                        begin
                            if (phase_inc >= sense_ticks)
                            begin
                                // Sensing window closes; an empty rest reopens it at once
                                have_ref_next    = 1'b0;
                                phase_count_next = '0;
                                if (rest_ticks == '0)
                                begin
                                    phase_next  = amwd_pkg::PH_SENSE;
                                    energy_next = '0;
                                end
                                else
                                begin
                                    phase_next = amwd_pkg::PH_REST;
                                end
                            end
                            else
                            begin
                                phase_count_next = phase_inc;
                            end
                        end
                        else if (phase_inc >= rest_ticks)
                        begin
                            phase_next       = amwd_pkg::PH_SENSE;
                            phase_count_next = '0;
                            energy_next      = '0;
                            have_ref_next    = 1'b0;
                        end
                        else
                        begin
                            phase_count_next = phase_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Verdict outputs
    always_comb
    begin
        verdict.valid  = 1'b0;
        verdict.moved  = 1'b0;
        verdict_energy = energy_reg;
        if (item_valid)
        begin
            case (op)
                amwd_pkg::OP_SAMPLE:
                begin
                    verdict.valid  = in_sense && over_limit;
                    verdict.moved  = 1'b1;
                    verdict_energy = sum_sat;
                end
                amwd_pkg::OP_MOTION:
                begin
                    verdict.valid = in_sense;
                    verdict.moved = 1'b1;
                end
                amwd_pkg::OP_TICK:
                begin
                    verdict.valid = (phase_reg != amwd_pkg::PH_IDLE) && overall_done;
                    verdict.moved = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= amwd_pkg::PH_IDLE;
            phase_count_reg   <= '0;
            overall_count_reg <= '0;
            energy_reg        <= '0;
            have_ref_reg      <= 1'b0;
            ref_x_reg         <= '0;
            ref_y_reg         <= '0;
            ref_z_reg         <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            phase_count_reg   <= phase_count_next;
            overall_count_reg <= overall_count_next;
            energy_reg        <= energy_next;
            have_ref_reg      <= have_ref_next;
            ref_x_reg         <= ref_x_next;
            ref_y_reg         <= ref_y_next;
            ref_z_reg         <= ref_z_next;
        end
    end

    // A verdict always leaves the detector idle
    a_verdict_idles: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |=> phase_reg == amwd_pkg::PH_IDLE)
        else $error("detector not idle after a verdict");

    // A reference is only held inside a sensing window
    a_ref_in_sense: assert property (@(posedge clk) disable iff (!rst_n)
        have_ref_reg |-> phase_reg == amwd_pkg::PH_SENSE)
        else $error("reference held outside sensing");

    // A start clears the energy
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && op == amwd_pkg::OP_START) |=> energy_reg == '0)
        else $error("energy not cleared by start");

endmodule

[hw/rtl/accel_motion_window_detector.sv]
`timescale 1ns / 1ps

// Accelerometer motion detector over alternating sensing and rest windows.
// One request is taken per clock unless the input side stalls. A request is
// captured in an input register and processed by the sequencer (three
// squarers, a saturating add and the threshold compare form the longest
// path) once the result register can take a verdict. Any verdict is loaded
// into the result register at the end of that same cycle, so it is presented
// in the cycle after its request is processed. While a result waits to be
// taken, one more request can be captured; the input side stalls only when a
// request is waiting behind a result register that is full and not being drained.
// The operation travels on tuser; samples on tdata. Configuration writes
// belong to idle periods.
module accel_motion_window_detector #(
    parameter int SAMPLE_BITS = amwd_pkg::SAMPLE_BITS_DEF,
    parameter int ENERGY_BITS = amwd_pkg::ENERGY_BITS_DEF,
    parameter int TICK_BITS   = amwd_pkg::TICK_BITS_DEF,
    localparam int IN_DATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((1 + ENERGY_BITS + 7) / 8) * 8,
    localparam int CFG_W      = (TICK_BITS > amwd_pkg::LIMIT_BITS) ?
                                TICK_BITS : amwd_pkg::LIMIT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_DATA_W-1:0]              s_axis_tdata,  // accel_x, accel_y, accel_z
    input  logic [amwd_pkg::OP_BITS-1:0]      s_axis_tuser,  // operation
    // Verdict stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [OUT_DATA_W-1:0]             m_axis_tdata,  // moved, energy_seen
    // Configuration
    input  logic                              cfg_we,
    input  logic [amwd_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_W-1:0]                  cfg_wdata
);

    logic [TICK_BITS-1:0]            sense_ticks_reg;
    logic [TICK_BITS-1:0]            rest_ticks_reg;
    logic [TICK_BITS-1:0]            overall_ticks_reg;
    logic [amwd_pkg::LIMIT_BITS-1:0] motion_limit_reg;
    logic                            repeated_mode_reg;

    logic                            in_valid_reg;
    logic [amwd_pkg::OP_BITS-1:0]    in_op_reg;
    logic signed [SAMPLE_BITS-1:0]   in_x_reg, in_y_reg, in_z_reg;

    logic                            out_valid_reg, out_valid_next;
    logic                            out_moved_reg;
    logic [ENERGY_BITS-1:0]          out_energy_reg;

    logic                            out_free;
    logic                            fire;
    amwd_pkg::verdict_t              verdict;
    logic [ENERGY_BITS-1:0]          verdict_energy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sense_ticks_reg   <= TICK_BITS'(amwd_pkg::SENSE_TICKS_RST);
            rest_ticks_reg    <= TICK_BITS'(amwd_pkg::REST_TICKS_RST);
            overall_ticks_reg <= TICK_BITS'(amwd_pkg::OVERALL_TICKS_RST);
            motion_limit_reg  <= amwd_pkg::LIMIT_BITS'(amwd_pkg::MOTION_LIMIT_RST);
            repeated_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                amwd_pkg::CFG_SENSE_TICKS:   sense_ticks_reg   <= cfg_wdata[TICK_BITS-1:0];
                amwd_pkg::CFG_REST_TICKS:    rest_ticks_reg    <= cfg_wdata[TICK_BITS-1:0];
                amwd_pkg::CFG_OVERALL_TICKS: overall_ticks_reg <= cfg_wdata[TICK_BITS-1:0];
                amwd_pkg::CFG_MOTION_LIMIT:
                    motion_limit_reg <= cfg_wdata[amwd_pkg::LIMIT_BITS-1:0];
                amwd_pkg::CFG_REPEATED_MODE: repeated_mode_reg <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake: a request is processed once the result slot can take a verdict
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg <= s_axis_tuser;
            in_x_reg  <= s_axis_tdata[SAMPLE_BITS-1:0];
            in_y_reg  <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            in_z_reg  <= s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
        end
    end

    amwd_seq #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENERGY_BITS (ENERGY_BITS),
        .TICK_BITS   (TICK_BITS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (fire),
        .op             (in_op_reg),
        .x              (in_x_reg),
        .y              (in_y_reg),
        .z              (in_z_reg),
        .sense_ticks    (sense_ticks_reg),
        .rest_ticks     (rest_ticks_reg),
        .overall_ticks  (overall_ticks_reg),
        .motion_limit   (motion_limit_reg),
        .repeated_mode  (repeated_mode_reg),
        .verdict        (verdict),
        .verdict_energy (verdict_energy)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (verdict.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (verdict.valid)
        begin
            out_moved_reg  <= verdict.moved;
            out_energy_reg <= verdict_energy;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_energy_reg, out_moved_reg});

    // An empty input register always takes a request
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while empty");

endmodule

[verif/tb_accel_motion_window_detector.sv]
`timescale 1ns / 1ps

module tb_accel_motion_window_detector;

    localparam int IN_W      = 48;
    localparam int OUT_W     = 56;
    localparam int CFG_W     = 32;
    localparam int TICK_W    = 24;
    localparam int ENERGY_W  = 48;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    // Margin left once every verdict is in
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 312;
    localparam int MAX_REPORTS   = 10;
    localparam int PREDICT       = -1;

    // Operation codes with no defined meaning
    localparam logic [amwd_pkg::OP_BITS-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [amwd_pkg::OP_BITS-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [amwd_pkg::OP_BITS-1:0] OP_RSVD_7 = 3'd7;

    localparam logic [ENERGY_W-1:0] ENERGY_SAT = '1;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RDY_FREE     = 2'd0,
        RDY_RANDOM   = 2'd1,
        RDY_PERIODIC = 2'd2
    } rdy_mode_t;

    typedef struct {
        bit                  moved;
        logic [ENERGY_W-1:0] energy;
    } verdict_rec_t;

    // Directed row: a request or a register write; n_res of PREDICT defers to the predictor
    typedef struct {
        bit                  is_cfg;
        logic [2:0]          code;
        logic [CFG_W-1:0]    wdata;
        logic [15:0]         ax;
        logic [15:0]         ay;
        logic [15:0]         az;
        int                  n_res;
        bit                  moved;
        logic [ENERGY_W-1:0] energy;
    } dir_row_t;

    localparam int DIR_ROWS = 31;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [IN_W-1:0]                   s_axis_tdata;   // accel_x, accel_y, accel_z
    logic [amwd_pkg::OP_BITS-1:0]      s_axis_tuser;   // operation
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]                  m_axis_tdata;   // moved, energy_seen
    logic                              cfg_we;
    logic [amwd_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_W-1:0]                  cfg_wdata;

    // Register copy
    logic [TICK_W-1:0]               reg_sense   = TICK_W'(amwd_pkg::SENSE_TICKS_RST);
    logic [TICK_W-1:0]               reg_rest    = TICK_W'(amwd_pkg::REST_TICKS_RST);
    logic [TICK_W-1:0]               reg_overall = TICK_W'(amwd_pkg::OVERALL_TICKS_RST);
    logic [amwd_pkg::LIMIT_BITS-1:0] reg_limit   =
        amwd_pkg::LIMIT_BITS'(amwd_pkg::MOTION_LIMIT_RST);
    logic                            reg_repeat  = 1'b0;

    // Detector state copy
    amwd_pkg::phase_t        mdl_phase   = amwd_pkg::PH_IDLE;
    logic [TICK_W-1:0]       win_count   = '0;
    logic [TICK_W-1:0]       run_count   = '0;
    logic [ENERGY_W-1:0]     energy_acc  = '0;
    bit                      anchor_ok   = 1'b0;
    logic signed [15:0]      anchor_x    = '0;
    logic signed [15:0]      anchor_y    = '0;
    logic signed [15:0]      anchor_z    = '0;

    verdict_rec_t            pending_verdicts[$];
    int                      mismatches   = 0;
    int                      quiet_cycles = 0;
    int                      burst_left   = 0;
    logic [7:0]              stall_cyc    = '0;
    rdy_mode_t               stall_mode   = RDY_FREE;

    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        // idle: everything but start is ignored, undefined codes included
        '{0, amwd_pkg::OP_TICK,   0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_SAMPLE, 0, 16'h0001, 16'h0002, 16'h0003, 0, 0, 0},
        '{0, amwd_pkg::OP_MOTION, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, OP_RSVD_5,           0, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0},
        '{0, OP_RSVD_6,           0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0},
        '{0, OP_RSVD_7,           0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0},
        // reference, small energy, then extreme swing
        '{0, amwd_pkg::OP_START,  0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_SAMPLE, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_SAMPLE, 0, 16'd10,   16'd10,   16'd10,   0, 0, 0},
        '{0, amwd_pkg::OP_SAMPLE, 0, 16'h8000, 16'h7FFF, 16'h8000, PREDICT, 0, 0},
        // significant motion event while sensing
        '{0, amwd_pkg::OP_START,  0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_SAMPLE, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0},
        '{0, amwd_pkg::OP_MOTION, 0, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0},
        // stop aborts, later sample and tick are ignored
        '{0, amwd_pkg::OP_START,  0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_STOP,   0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_SAMPLE, 0, 16'd5,    16'd5,    16'd5,    0, 0, 0},
        '{0, amwd_pkg::OP_TICK,   0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        // one-tick windows, no rest, stillness on the third tick
        '{1, amwd_pkg::CFG_SENSE_TICKS,   32'd1,         0, 0, 0, 0, 0, 0},
        '{1, amwd_pkg::CFG_REST_TICKS,    32'd0,         0, 0, 0, 0, 0, 0},
        '{1, amwd_pkg::CFG_OVERALL_TICKS, 32'd3,         0, 0, 0, 0, 0, 0},
        '{1, amwd_pkg::CFG_MOTION_LIMIT,  32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
        '{1, amwd_pkg::CFG_REPEATED_MODE, 32'd1,         0, 0, 0, 0, 0, 0},
        '{0, amwd_pkg::OP_START,  0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_TICK,   0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_TICK,   0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_TICK,   0, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0},
        // repeated mode: limit 30 / 15 = 2, equal is not above
        '{1, amwd_pkg::CFG_MOTION_LIMIT,  32'd30,        0, 0, 0, 0, 0, 0},
        '{0, amwd_pkg::OP_START,  0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_SAMPLE, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_SAMPLE, 0, 16'h0001, 16'h0001, 16'h0000, 0, 0, 0},
        '{0, amwd_pkg::OP_SAMPLE, 0, 16'h0001, 16'h0001, 16'h0001, 1, 1, 5}
    };

    accel_motion_window_detector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // ---------------------------------------------------------------
    // Detector prediction
    // ---------------------------------------------------------------
    task automatic drop_anchor();
        anchor_ok = 1'b0;
        anchor_x  = '0;
        anchor_y  = '0;
        anchor_z  = '0;
    endtask

    task automatic open_window();
        mdl_phase  = amwd_pkg::PH_SENSE;
        win_count  = '0;
        energy_acc = '0;
        drop_anchor();
    endtask

    task automatic give_verdict(input bit moved, output bit fired, output verdict_rec_t res);
        fired      = 1'b1;
        res.moved  = moved;
        res.energy = energy_acc;
        mdl_phase  = amwd_pkg::PH_IDLE;
        win_count  = '0;
        drop_anchor();
    endtask

    task automatic detector_step(input logic [2:0] op, input logic [15:0] sx, sy, sz,
                                 output bit fired, output verdict_rec_t res);
        longint     dx;
        longint     dy;
        longint     dz;
        logic [63:0] add;
        logic [63:0] lim;
        fired = 1'b0;
        res   = '{1'b0, '0};
        case (op)
            amwd_pkg::OP_START:
            begin
                run_count = '0;
                open_window();
            end
            amwd_pkg::OP_STOP:
            begin
                mdl_phase = amwd_pkg::PH_IDLE;
                win_count = '0;
                drop_anchor();
            end
            amwd_pkg::OP_SAMPLE:
            begin
                if (mdl_phase == amwd_pkg::PH_SENSE)
                begin
                    if (!anchor_ok)
                    begin
                        anchor_ok = 1'b1;
                        anchor_x  = signed'(sx);
                        anchor_y  = signed'(sy);
                        anchor_z  = signed'(sz);
                    end
                    dx  = longint'(signed'(sx)) - longint'(anchor_x);
                    dy  = longint'(signed'(sy)) - longint'(anchor_y);
                    dz  = longint'(signed'(sz)) - longint'(anchor_z);
                    add = 64'(dx * dx + dy * dy + dz * dz);
                    // saturating accumulate
                    if (add > 64'(ENERGY_SAT) - 64'(energy_acc))
                        energy_acc = ENERGY_SAT;
                    else
                        energy_acc = energy_acc + add[ENERGY_W-1:0];
                    lim = reg_repeat ? 64'(reg_limit) / 64'(amwd_pkg::LIMIT_DIV)
                                     : 64'(reg_limit);
                    if (64'(energy_acc) > lim)
                        give_verdict(1'b1, fired, res);
                end
            end
            amwd_pkg::OP_MOTION:
            begin
                if (mdl_phase == amwd_pkg::PH_SENSE)
                    give_verdict(1'b1, fired, res);
            end
            amwd_pkg::OP_TICK:
            begin
                if (mdl_phase != amwd_pkg::PH_IDLE)
                begin
                    // overall timeout takes priority over the window count
                    run_count = run_count + 1'b1;
                    if (run_count >= reg_overall)
                        give_verdict(1'b0, fired, res);
                    else
                    begin
                        win_count = win_count + 1'b1;
                        if (mdl_phase == amwd_pkg::PH_SENSE)
                        begin
                            if (win_count >= reg_sense)
                            begin
                                drop_anchor();
                                mdl_phase = amwd_pkg::PH_REST;
                                win_count = '0;
                                if (reg_rest == '0)
                                    open_window();
                            end
                        end
                        else if (win_count >= reg_rest)
                            open_window();
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    task automatic send_request(input logic [2:0] op, input logic [15:0] sx, sy, sz,
                                input int n_res, input verdict_rec_t typed);
        int           gap;
        bit           fired;
        verdict_rec_t res;
        // bursts with random gaps between them
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {sz, sy, sx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        detector_step(op, sx, sy, sz, fired, res);
        if (n_res == PREDICT)
        begin
            if (fired)
                pending_verdicts.push_back(res);
        end
        else if (n_res > 0)
            pending_verdicts.push_back(typed);
    endtask

    // Hold requests back until every verdict is in and the pipe is empty
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            amwd_pkg::CFG_SENSE_TICKS:   reg_sense   = val[TICK_W-1:0];
            amwd_pkg::CFG_REST_TICKS:    reg_rest    = val[TICK_W-1:0];
            amwd_pkg::CFG_OVERALL_TICKS: reg_overall = val[TICK_W-1:0];
            amwd_pkg::CFG_MOTION_LIMIT:  reg_limit   = val[amwd_pkg::LIMIT_BITS-1:0];
            amwd_pkg::CFG_REPEATED_MODE: reg_repeat  = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] sense, rest, overall, limit, rep);
        quiesce();
        write_register(amwd_pkg::CFG_SENSE_TICKS, sense);
        write_register(amwd_pkg::CFG_REST_TICKS, rest);
        write_register(amwd_pkg::CFG_OVERALL_TICKS, overall);
        write_register(amwd_pkg::CFG_MOTION_LIMIT, limit);
        write_register(amwd_pkg::CFG_REPEATED_MODE, rep);
    endtask

    // Small signed offset of random scale
    function automatic logic [15:0] jitter();
        logic [15:0] d;
        d = 16'($urandom) >> $urandom_range(0, 15);
        return ($urandom_range(0, 1) != 0) ? -d : d;
    endfunction

    // Mostly started runs of samples and ticks, with aborts and noise mixed in
    task automatic run_random(input int n_items);
        int          taken;
        int          pick;
        logic [2:0]  op;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] sz;
        logic [15:0] base_x;
        logic [15:0] base_y;
        logic [15:0] base_z;
        taken  = 0;
        base_x = 16'($urandom);
        base_y = 16'($urandom);
        base_z = 16'($urandom);
        while (taken < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (mdl_phase == amwd_pkg::PH_IDLE)
                op = (pick < 70) ? amwd_pkg::OP_START : 3'($urandom_range(0, 7));
            else if (pick < 50)
                op = amwd_pkg::OP_SAMPLE;
            else if (pick < 80)
                op = amwd_pkg::OP_TICK;
            else if (pick < 83)
                op = amwd_pkg::OP_MOTION;
            else if (pick < 86)
                op = amwd_pkg::OP_STOP;
            else if (pick < 90)
                op = amwd_pkg::OP_START;
            else
                op = 3'($urandom_range(5, 7));
            if (op == amwd_pkg::OP_START)
            begin
                base_x = 16'($urandom);
                base_y = 16'($urandom);
                base_z = 16'($urandom);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                sx = 16'($urandom);
                sy = 16'($urandom);
                sz = 16'($urandom);
            end
            else
            begin
                sx = base_x + jitter();
                sy = base_y + jitter();
                sz = base_z + jitter();
            end
            send_request(op, sx, sy, sz, PREDICT, '{1'b0, '0});
            taken++;
            if ($urandom_range(0, 199) == 0)
                quiesce();
        end
    endtask

    // ---------------------------------------------------------------
    // Verdict side: stall pattern and checking
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        stall_cyc <= stall_cyc + 1'b1;
        if (stall_cyc[6:0] == '0)
            stall_mode <= rdy_mode_t'($urandom_range(0, 2));
        case (stall_mode)
            RDY_FREE:     m_axis_tready <= 1'b1;
            RDY_RANDOM:   m_axis_tready <= ($urandom_range(0, 9) < 6);
            default:      m_axis_tready <= (stall_cyc[1:0] == 2'd0);
        endcase
    end

    always @(posedge clk)
    begin
        verdict_rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected verdict: moved=%0d energy=%0d",
                             m_axis_tdata[0], m_axis_tdata[ENERGY_W:1]);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.moved ||
                    m_axis_tdata[ENERGY_W:1] !== want.energy)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display({"verdict mismatch: expected moved=%0d energy=%0d,",
                                  " got moved=%0d energy=%0d"},
                                 want.moved, want.energy,
                                 m_axis_tdata[0], m_axis_tdata[ENERGY_W:1]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        do
            @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT);
        $display("[accel_motion_window_detector] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                quiesce();
                write_register(dir_tab[i].code, dir_tab[i].wdata);
            end
            else
                send_request(dir_tab[i].code, dir_tab[i].ax, dir_tab[i].ay, dir_tab[i].az,
                             dir_tab[i].n_res, '{dir_tab[i].moved, dir_tab[i].energy});
        end

        // random phases; zero and all-ones register settings first
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_config('0, '0, '0, '0, '0);
                1: set_config(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF,
                              32'hFFFF_FFFF, 32'd1);
                default:
                    set_config($urandom_range(0, 12), $urandom_range(0, 8),
                               $urandom_range(1, 80), $urandom >> $urandom_range(0, 31),
                               $urandom_range(0, 1));
            endcase
            run_random(PHASE_ITEMS);
        end

        quiesce();
        if (mismatches == 0)
            $display("[accel_motion_window_detector] OK");
        else
            $display("[accel_motion_window_detector] ERROR");
        $finish;
    end

endmodule

[accel_motion_window_detector.f]
hw/rtl/amwd_pkg.sv
hw/rtl/amwd_energy.sv
hw/rtl/amwd_seq.sv
hw/rtl/accel_motion_window_detector.sv
verif/tb_accel_motion_window_detector.sv
